@@ rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the barometric compensation core
// Field widths, calibration register indices and the words passed between
// the temperature front end and the pressure back end.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Field widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Internal widths: dT, coefficient products, OFF and SENS, the split of SENS and the pressure path
  localparam int DT_W      = RAW_W + 1;
  localparam int PROD_W    = DT_W + COEF_W + 1;
  localparam int OFF_W     = 36;
  localparam int SENS_W    = 35;
  localparam int SENS_LO_W = 18;
  localparam int SENS_HI_W = SENS_W - SENS_LO_W;
  localparam int FULL_W    = 60;
  localparam int SCALED_W  = FULL_W - 21;
  localparam int DIFF_W    = SCALED_W + 1;

  // Shift amounts of the compensation formula
  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 6;
  localparam int SENS_SHIFT = 7;
  localparam int PRES_SHIFT = 15;

  // Temperature offset, 20.00 degrees in hundredths
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  // Calibration register indices
  localparam logic [CFG_IDX_W-1:0] REG_PRES_SENS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_OFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

  // Calibration words as held by the core
  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } bpc_coef_t;

  // Word handed from the front end to the back end
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } bpc_mid_t;

endpackage

@@ rtl/bpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front: temperature path and OFF / SENS terms
// Three stages: dT, the three calibration products, then temperature,
// OFF and SENS. Each stage holds its word until the next one takes it.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpc_pkg::bpc_coef_t                 coef,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bpc_pkg::RAW_W-1:0]          raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]          raw_temperature,
  output logic                               mid_valid,
  input  logic                               mid_ready,
  output bpc_pkg::bpc_mid_t                  mid
);
  import bpc_pkg::*;

  logic [2:0]               vld_r;
  logic [2:0]               vld_nxt;
  logic [2:0]               rdy;

  logic [RAW_W-1:0]         d1_s1_r;
  logic signed [DT_W-1:0]   dt_s1_r;
  logic signed [DT_W-1:0]   dt_nxt;

  logic [RAW_W-1:0]         d1_s2_r;
  logic signed [PROD_W-1:0] pt_s2_r;
  logic signed [PROD_W-1:0] po_s2_r;
  logic signed [PROD_W-1:0] ps_s2_r;
  logic signed [PROD_W-1:0] pt_nxt;
  logic signed [PROD_W-1:0] po_nxt;
  logic signed [PROD_W-1:0] ps_nxt;

  bpc_mid_t                 mid_r;
  bpc_mid_t                 mid_nxt;

  // Advance a stage when it is empty or the one after it moves on
  assign rdy[2]   = !vld_r[2] || mid_ready;
  assign rdy[1]   = !vld_r[1] || rdy[2];
  assign rdy[0]   = !vld_r[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    vld_nxt[1] = rdy[1] ? vld_r[0] : vld_r[1];
    vld_nxt[2] = rdy[2] ? vld_r[1] : vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: dT = D2 - C5 * 256
  assign dt_nxt = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'h00});

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      d1_s1_r <= raw_pressure;
      dt_s1_r <= dt_nxt;
    end
  end

  // Stage 2: multiply dT by C6, C4 and C3
  always_comb begin
    pt_nxt = dt_s1_r * $signed({1'b0, coef.c6});
    po_nxt = dt_s1_r * $signed({1'b0, coef.c4});
    ps_nxt = dt_s1_r * $signed({1'b0, coef.c3});
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_r[0]) begin
      d1_s2_r <= d1_s1_r;
      pt_s2_r <= pt_nxt;
      po_s2_r <= po_nxt;
      ps_s2_r <= ps_nxt;
    end
  end

  // Stage 3: scale the products and add the base terms
  always_comb begin
    mid_nxt.d1   = d1_s2_r;
    mid_nxt.temp = TEMP_BASE + TEMP_W'(pt_s2_r >>> TEMP_SHIFT);
    mid_nxt.off  = $signed({3'b000, coef.c2, 17'h00000})
                 + OFF_W'(po_s2_r >>> OFF_SHIFT);
    mid_nxt.sens = $signed({3'b000, coef.c1, 16'h0000})
                 + SENS_W'(ps_s2_r >>> SENS_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && vld_r[1]) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = vld_r[2];
  assign mid       = mid_r;

  // Checks
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> (vld_r == 3'b000))
    else $error("front pipeline not empty after reset");

  a_fill_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !vld_r[1]) |=> vld_r[1])
    else $error("word did not advance into an empty stage");

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && !mid_ready) |=> (vld_r[2] && $stable(mid_r)))
    else $error("front output word lost while held");

endmodule

@@ rtl/bpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back: pressure path
// Three stages: split D1 * SENS into two partial products, join them and
// scale by 2^-21, then subtract OFF and scale by 2^-15 into the output word.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                mid_valid,
  output logic                                mid_ready,
  input  bpc_pkg::bpc_mid_t                   mid,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi,
  output logic signed [bpc_pkg::PRES_W-1:0]   pressure_centi
);
  import bpc_pkg::*;

  localparam int PL_W = RAW_W + SENS_LO_W;
  localparam int PH_W = RAW_W + 1 + SENS_HI_W;

  logic [2:0]                 vld_r;
  logic [2:0]                 vld_nxt;
  logic [2:0]                 rdy;

  logic [PL_W-1:0]            pl_s4_r;
  logic signed [PH_W-1:0]     ph_s4_r;
  logic signed [TEMP_W-1:0]   temp_s4_r;
  logic signed [OFF_W-1:0]    off_s4_r;
  logic [PL_W-1:0]            pl_nxt;
  logic signed [PH_W-1:0]     ph_nxt;

  logic signed [SCALED_W-1:0] scaled_s5_r;
  logic signed [TEMP_W-1:0]   temp_s5_r;
  logic signed [OFF_W-1:0]    off_s5_r;
  logic signed [FULL_W-1:0]   full_nxt;

  logic signed [DIFF_W-1:0]   diff_nxt;
  logic signed [TEMP_W-1:0]   temp_out_r;
  logic signed [PRES_W-1:0]   pres_out_r;

  // Advance a stage when it is empty or the one after it moves on
  assign rdy[2]    = !vld_r[2] || out_ready;
  assign rdy[1]    = !vld_r[1] || rdy[2];
  assign rdy[0]    = !vld_r[0] || rdy[1];
  assign mid_ready = rdy[0];

  always_comb begin
    vld_nxt[0] = rdy[0] ? mid_valid : vld_r[0];
    vld_nxt[1] = rdy[1] ? vld_r[0] : vld_r[1];
    vld_nxt[2] = rdy[2] ? vld_r[1] : vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 4: D1 times the low and high parts of SENS
  always_comb begin
    pl_nxt = PL_W'(mid.d1) * PL_W'(mid.sens[SENS_LO_W-1:0]);
    ph_nxt = $signed({1'b0, mid.d1}) * $signed(mid.sens[SENS_W-1:SENS_LO_W]);
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && mid_valid) begin
      pl_s4_r   <= pl_nxt;
      ph_s4_r   <= ph_nxt;
      temp_s4_r <= mid.temp;
      off_s4_r  <= mid.off;
    end
  end

  // Stage 5: join the partial products, floor-shift by 21
  assign full_nxt = $signed({ph_s4_r, {SENS_LO_W{1'b0}}})
                  + $signed({{(FULL_W - PL_W){1'b0}}, pl_s4_r});

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_r[0]) begin
      scaled_s5_r <= full_nxt[FULL_W-1:FULL_W-SCALED_W];
      temp_s5_r   <= temp_s4_r;
      off_s5_r    <= off_s4_r;
    end
  end

  // Stage 6: subtract OFF, floor-shift by 15 into the output register
  assign diff_nxt = DIFF_W'(scaled_s5_r) - DIFF_W'(off_s5_r);

  always_ff @(posedge clk) begin
    if (rdy[2] && vld_r[1]) begin
      temp_out_r <= temp_s5_r;
      pres_out_r <= diff_nxt[PRES_SHIFT+PRES_W-1:PRES_SHIFT];
    end
  end

  assign out_valid         = vld_r[2];
  assign temperature_centi = temp_out_r;
  assign pressure_centi    = pres_out_r;

  // Checks
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> (vld_r == 3'b000))
    else $error("back pipeline not empty after reset");

  a_fill_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !vld_r[2]) |=> vld_r[2])
    else $error("word did not advance into the empty output stage");

  a_hold_join: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !rdy[2]) |=> (vld_r[1] && $stable(scaled_s5_r)))
    else $error("joined product changed while held");

endmodule

@@ rtl/baro_pressure_temp_compensation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core: first-order barometric compensation
// Each accepted word passes all six stages, front then back, to out_valid.
// Throughput: one word per cycle while out_stall is low; set by the pipeline.
// A stalled output holds its word; empty stages still fill behind it.
// Reset clears all stage valid bits and the six calibration words to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bpc_pkg::RAW_W-1:0]            in_raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]            in_raw_temperature,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bpc_pkg::TEMP_W-1:0]    out_temperature_centi,
  output logic signed [bpc_pkg::PRES_W-1:0]    out_pressure_centi
);
  import bpc_pkg::*;

  bpc_coef_t coef_r;
  bpc_coef_t coef_nxt;
  logic      in_ready;
  logic      mid_valid;
  logic      mid_ready;
  bpc_mid_t  mid;

  // Calibration register write; drop writes beyond the last index
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRES_SENS:  coef_nxt.c1 = cfg_data;
        REG_PRES_OFF:   coef_nxt.c2 = cfg_data;
        REG_SENS_TEMP:  coef_nxt.c3 = cfg_data;
        REG_OFF_TEMP:   coef_nxt.c4 = cfg_data;
        REG_REF_TEMP:   coef_nxt.c5 = cfg_data;
        REG_TEMP_SLOPE: coef_nxt.c6 = cfg_data;
        default:        coef_nxt    = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // Temperature, OFF and SENS
  bpc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .coef            (coef_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .mid_valid       (mid_valid),
    .mid_ready       (mid_ready),
    .mid             (mid)
  );

  // Pressure
  bpc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mid_valid         (mid_valid),
    .mid_ready         (mid_ready),
    .mid               (mid),
    .out_valid         (out_valid),
    .out_ready         (!out_stall),
    .temperature_centi (out_temperature_centi),
    .pressure_centi    (out_pressure_centi)
  );

  assign in_stall = !in_ready;

  // Checks
  a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && (cfg_index > REG_TEMP_SLOPE)) |=> $stable(coef_r))
    else $error("write beyond the last register changed calibration");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !mid_valid) |-> !in_stall)
    else $error("input stalled with both halves drained at their outputs");

  a_reset_cfg: assert property (@(posedge clk) !rst_n |=> (coef_r == '0))
    else $error("calibration words not cleared by reset");

endmodule
